// ----- src/lpm_pkg.sv -----
// Shared constants and controller/datapath interface types for the linear partition core.
`default_nettype none

package lpm_pkg;

    localparam int MAX_ITEMS_DEF  = 512;
    localparam int VALUE_BITS_DEF = 32;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 9;
    localparam int PART_W  = 10;
    localparam int BOUND_W = 41;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic KIND_BOUND = 1'b0;
    localparam logic KIND_FLAG  = 1'b1;

    typedef struct packed {
        logic search_init;
        logic mid_calc;
        logic scan_start;
        logic scan_final;
        logic scan_step;
        logic eval;
        logic xtra_start;
        logic xtra_read;
        logic xtra_write;
        logic finish;
    } lpm_cmd_t;

    typedef struct packed {
        logic lo_lt_hi;
        logic scan_end;
        logic xtra_go;
        logic xtra_more;
    } lpm_status_t;

endpackage

`default_nettype wire

// ----- src/lpm_ctrl.sv -----
// Search sequencer: binary search loop, greedy scans, extra-split pass and result strobe.
`default_nettype none

module lpm_ctrl
    import lpm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        search_go,
    input  wire lpm_status_t status,
    output lpm_cmd_t         cmd,
    output logic             busy
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_LOOP  = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_EVAL  = 4'd4;
    localparam logic [3:0] ST_FSCAN = 4'd5;
    localparam logic [3:0] ST_XCHK  = 4'd6;
    localparam logic [3:0] ST_XRD   = 4'd7;
    localparam logic [3:0] ST_XWR   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (search_go)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.search_init = 1'b1;
                state_next      = ST_LOOP;
            end
            ST_LOOP:
            begin
                cmd.scan_start = 1'b1;
                if (status.lo_lt_hi)
                begin
                    cmd.mid_calc = 1'b1;
                    state_next   = ST_SCAN;
                end
                else
                begin
                    cmd.scan_final = 1'b1;
                    state_next     = ST_FSCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_end)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_LOOP;
            end
            ST_FSCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_end)
                begin
                    state_next = ST_XCHK;
                end
            end
            ST_XCHK:
            begin
                cmd.xtra_start = 1'b1;
                state_next     = status.xtra_go ? ST_XRD : ST_DONE;
            end
            ST_XRD:
            begin
                cmd.xtra_read = 1'b1;
                state_next    = ST_XWR;
            end
            ST_XWR:
            begin
                cmd.xtra_write = 1'b1;
                state_next     = status.xtra_more ? ST_XRD : ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ----- src/lpm_datapath.sv -----
// Value and split-flag stores, sequence totals, search bounds and greedy packing datapath.
`default_nettype none

module lpm_datapath
    import lpm_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load_en,
    input  wire logic               query_en,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [INDEX_W-1:0] index,
    input  wire logic [PART_W-1:0]  part_count,
    input  wire lpm_cmd_t           cmd,
    output lpm_status_t             status,
    output logic                    result_valid,
    output logic                    result_kind,
    output logic [BOUND_W-1:0]      bottleneck,
    output logic                    split_after
);

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int VW  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int TW  = VW + CW;
    localparam int PW  = ((CW > PART_W) ? CW : PART_W) + 1;
    localparam int IXW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int BW  = (TW > BOUND_W) ? TW : BOUND_W;

    logic [VW-1:0] values_mem [MAX_ITEMS];
    logic          flag_mem   [MAX_ITEMS];

    logic [VW-1:0] val_rd_reg;
    logic          flag_rd_reg;

    logic [CW-1:0] item_count_reg;
    logic [TW-1:0] total_reg;
    logic [VW-1:0] smallest_reg;
    logic [CW-1:0] flag_count_reg;
    logic          q_valid_reg;
    logic          q_hit_reg;

    logic [TW-1:0] lo_reg;
    logic [TW-1:0] hi_reg;
    logic [TW-1:0] mid_reg;
    logic [TW-1:0] acc_reg;

    logic [CW-1:0] rem_reg;
    logic [AW-1:0] nxt_addr_reg;
    logic          took_reg;
    logic          fail_reg;
    logic          final_reg;
    logic [CW-1:0] breaks_reg;
    logic [AW-1:0] xi_reg;
    logic [PW-1:0] xparts_reg;

    logic [VW-1:0]  load_val;
    logic           store_open;
    logic [CW-1:0]  cnt_m1;
    logic [CW-1:0]  cnt_m2;
    logic [AW-1:0]  val_rd_addr;
    logic [TW-1:0]  lim;
    logic [TW:0]    sum;
    logic           fits;
    logic           v_fits;
    logic           brk;
    logic           fail_now;
    logic [CW-1:0]  elem;
    logic [TW:0]    sum_lh;
    logic           feasible;
    logic [PW-1:0]  pc_ext;
    logic [PW-1:0]  parts_final;
    logic [PW-1:0]  xparts_nxt;
    logic [IXW-1:0] idx_ext;
    logic [AW-1:0]  flag_rd_addr;
    logic           flag_we;
    logic [AW-1:0]  flag_wr_addr;
    logic           flag_wr_data;
    logic [BW-1:0]  bound_ext;

    assign load_val    = value[VW-1:0];
    assign store_open  = (item_count_reg < CW'(MAX_ITEMS));
    assign cnt_m1      = item_count_reg - CW'(1);
    assign cnt_m2      = item_count_reg - CW'(2);
    assign val_rd_addr = cmd.scan_start ? cnt_m1[AW-1:0] : nxt_addr_reg;

    assign lim      = final_reg ? hi_reg : mid_reg;
    assign sum      = {1'b0, acc_reg} + (TW+1)'(val_rd_reg);
    assign fits     = (sum <= (TW+1)'(lim));
    assign v_fits   = (TW'(val_rd_reg) <= lim);
    assign brk      = !fits && took_reg && v_fits;
    assign fail_now = !fits && !brk;
    assign elem     = rem_reg - CW'(1);

    assign sum_lh      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign pc_ext      = PW'(part_count);
    assign parts_final = PW'(breaks_reg) + PW'(1);
    assign feasible    = !fail_reg && (parts_final <= pc_ext);
    assign xparts_nxt  = xparts_reg + PW'(!flag_rd_reg);

    assign idx_ext      = IXW'(index);
    assign flag_rd_addr = cmd.xtra_read ? xi_reg : idx_ext[AW-1:0];

    assign status.lo_lt_hi  = (lo_reg < hi_reg);
    assign status.scan_end  = (rem_reg == CW'(1)) || fail_now;
    assign status.xtra_go   = (item_count_reg > CW'(1)) && (parts_final < pc_ext);
    assign status.xtra_more = (((CW+1)'(xi_reg) + (CW+1)'(2)) < (CW+1)'(item_count_reg))
                              && (xparts_nxt < pc_ext);

    always_comb
    begin
        flag_we      = 1'b0;
        flag_wr_addr = elem[AW-1:0];
        flag_wr_data = brk;
        if (cmd.scan_step && final_reg)
        begin
            flag_we = 1'b1;
        end
        else if (cmd.xtra_write && !flag_rd_reg)
        begin
            flag_we      = 1'b1;
            flag_wr_addr = xi_reg;
            flag_wr_data = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en && store_open)
        begin
            values_mem[item_count_reg[AW-1:0]] <= load_val;
        end
        val_rd_reg <= values_mem[val_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_wr_addr] <= flag_wr_data;
        end
        flag_rd_reg <= flag_mem[flag_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= '0;
            total_reg      <= '0;
            smallest_reg   <= '1;
            flag_count_reg <= '0;
            q_valid_reg    <= 1'b0;
            q_hit_reg      <= 1'b0;
            rem_reg        <= '0;
            nxt_addr_reg   <= '0;
            took_reg       <= 1'b0;
            fail_reg       <= 1'b0;
            final_reg      <= 1'b0;
            breaks_reg     <= '0;
            xi_reg         <= '0;
            xparts_reg     <= '0;
        end
        else
        begin
            q_valid_reg <= query_en;
            if (query_en)
            begin
                q_hit_reg <= (idx_ext < IXW'(flag_count_reg));
            end

            if (cmd.finish)
            begin
                item_count_reg <= '0;
                total_reg      <= '0;
                smallest_reg   <= '1;
            end
            else if (load_en && store_open)
            begin
                item_count_reg <= item_count_reg + CW'(1);
                total_reg      <= total_reg + TW'(load_val);
                if (load_val < smallest_reg)
                begin
                    smallest_reg <= load_val;
                end
            end

            if (cmd.scan_start)
            begin
                rem_reg      <= item_count_reg;
                nxt_addr_reg <= cnt_m2[AW-1:0];
                took_reg     <= 1'b0;
                fail_reg     <= 1'b0;
                final_reg    <= cmd.scan_final;
                breaks_reg   <= '0;
            end
            else if (cmd.scan_step)
            begin
                rem_reg      <= elem;
                nxt_addr_reg <= nxt_addr_reg - AW'(1);
                fail_reg     <= fail_now;
                if (fits)
                begin
                    took_reg <= 1'b1;
                end
                else if (brk)
                begin
                    breaks_reg <= breaks_reg + CW'(1);
                end
            end

            if (cmd.xtra_start)
            begin
                xi_reg         <= '0;
                xparts_reg     <= parts_final;
                flag_count_reg <= item_count_reg;
            end
            else if (cmd.xtra_write)
            begin
                xi_reg     <= xi_reg + AW'(1);
                xparts_reg <= xparts_nxt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            lo_reg <= TW'(smallest_reg);
            hi_reg <= total_reg;
        end
        else if (cmd.eval)
        begin
            if (feasible)
            begin
                hi_reg <= mid_reg;
            end
            else
            begin
                lo_reg <= mid_reg + TW'(1);
            end
        end

        if (cmd.mid_calc)
        begin
            mid_reg <= sum_lh[TW:1];
        end

        if (cmd.scan_start)
        begin
            acc_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (fits)
            begin
                acc_reg <= sum[TW-1:0];
            end
            else if (brk)
            begin
                acc_reg <= TW'(val_rd_reg);
            end
        end
    end

    assign bound_ext    = BW'(hi_reg);
    assign result_valid = q_valid_reg || cmd.finish;
    assign result_kind  = q_valid_reg ? KIND_FLAG : KIND_BOUND;
    assign bottleneck   = q_valid_reg ? '0 : bound_ext[BOUND_W-1:0];
    assign split_after  = q_valid_reg && flag_rd_reg && q_hit_reg;

endmodule

`default_nettype wire

// ----- src/linear_partition_min_max_sum_core.sv -----
// Top level: accepts loads and queries, holds part_count, joins sequencer and datapath.
// Load: one item per cycle while not busy, no result. Query: result strobed the cycle
// after accept. Load with last: busy while searching, result strobed on the final busy
// cycle; the binary search takes at most as many steps as the total width. Each search
// step is one streamed pass over the value store at one element per cycle.
// Reset: counters clear, part_count is 1, split flags read zero until the first search.
`default_nettype none

module linear_partition_min_max_sum_core
    import lpm_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               func,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               last,
    input  wire logic [INDEX_W-1:0] index,
    output logic                    result_valid,
    output logic                    result_kind,
    output logic [BOUND_W-1:0]      bottleneck,
    output logic                    split_after,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [PART_W-1:0]  cfg_data
);

    logic [PART_W-1:0] part_count_reg;
    logic              item_accept;
    logic              load_en;
    logic              query_en;
    logic              search_go;
    lpm_cmd_t          cmd;
    lpm_status_t       status;

    assign cfg_ready   = 1'b1;
    assign item_accept = start && !busy;
    assign load_en     = item_accept && (func == FUNC_LOAD);
    assign query_en    = item_accept && (func == FUNC_QUERY);
    assign search_go   = load_en && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_count_reg <= PART_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            part_count_reg <= cfg_data;
        end
    end

    lpm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .search_go (search_go),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    lpm_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_en      (load_en),
        .query_en     (query_en),
        .value        (value),
        .index        (index),
        .part_count   (part_count_reg),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .bottleneck   (bottleneck),
        .split_after  (split_after)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the linear partition core: scoreboard with partition predictor, drivers, checks.
`timescale 1ns / 1ps

module tb_top;
    import lpm_pkg::*;

    localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
    localparam int ITEM_TARGET = 850;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic               kind;
        logic [BOUND_W-1:0] bound;
        logic               flag;
    } outcome_t;

    class partition_scoreboard;
        logic [VALUE_W-1:0] elems [MAX_ITEMS];
        bit [MAX_ITEMS-1:0] split;
        int                 count;
        logic [63:0]        total;
        logic [63:0]        smallest;
        logic [BOUND_W-1:0] bound;
        int                 parts_wanted;
        outcome_t           due_answers[$];
        int                 mismatches;
        int                 loads;
        int                 queries;
        int                 searches;

        function new();
            split        = '0;
            count        = 0;
            total        = '0;
            smallest     = 64'hFFFF_FFFF;
            bound        = '0;
            parts_wanted = 1;
            mismatches   = 0;
            loads        = 0;
            queries      = 0;
            searches     = 0;
        endfunction

        function void set_part_count(logic [PART_W-1:0] pc);
            parts_wanted = int'(pc);
        endfunction

        function int pending();
            return due_answers.size();
        endfunction

        // greedy right-to-left packing under lim; marks split points
        function int pack_greedy(logic [63:0] lim);
            int          parts;
            int          pos;
            logic [63:0] acc;
            bit          took;
            parts = 0;
            pos   = count;
            split = '0;
            while (pos > 0) begin
                acc  = '0;
                took = 1'b0;
                while (pos > 0 && acc + {32'h0, elems[pos-1]} <= lim) begin
                    acc  = acc + {32'h0, elems[pos-1]};
                    took = 1'b1;
                    pos--;
                end
                if (!took)
                    return parts_wanted + 1;
                if (pos > 0)
                    split[pos-1] = 1'b1;
                parts++;
            end
            return parts;
        endfunction

        function void solve_partition();
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] mid;
            int          parts;
            lo = smallest;
            hi = total;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (pack_greedy(mid) <= parts_wanted)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            bound = hi[BOUND_W-1:0];
            parts = pack_greedy(hi);
            // fill leftmost free positions up to the wanted part count
            for (int i = 0; i + 1 < count && parts < parts_wanted; i++) begin
                if (!split[i]) begin
                    split[i] = 1'b1;
                    parts++;
                end
            end
        endfunction

        function void note_item(logic op, logic [VALUE_W-1:0] elem, logic close,
                                logic [INDEX_W-1:0] pos);
            outcome_t ans;
            if (op == FUNC_QUERY) begin
                ans.kind  = KIND_FLAG;
                ans.bound = '0;
                ans.flag  = split[pos];
                due_answers.push_back(ans);
                queries++;
            end
            else begin
                loads++;
                if (count < MAX_ITEMS) begin
                    elems[count] = elem;
                    count++;
                    total = total + {32'h0, elem};
                    if ({32'h0, elem} < smallest)
                        smallest = {32'h0, elem};
                end
                if (close) begin
                    solve_partition();
                    count     = 0;
                    total     = '0;
                    smallest  = 64'hFFFF_FFFF;
                    ans.kind  = KIND_BOUND;
                    ans.bound = bound;
                    ans.flag  = 1'b0;
                    due_answers.push_back(ans);
                    searches++;
                end
            end
        endfunction

        function void check_result(logic kind, logic [BOUND_W-1:0] bn, logic flag);
            outcome_t want;
            if (due_answers.size() == 0) begin
                $error("unexpected result: result_kind=%0d bottleneck=%0d split_after=%0d",
                       kind, bn, flag);
                mismatches++;
                return;
            end
            want = due_answers.pop_front();
            if (kind !== want.kind) begin
                $error("result_kind: expected %0d, actual %0d", want.kind, kind);
                mismatches++;
            end
            if (bn !== want.bound) begin
                $error("bottleneck: expected %0d, actual %0d", want.bound, bn);
                mismatches++;
            end
            if (flag !== want.flag) begin
                $error("split_after: expected %0d, actual %0d", want.flag, flag);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               func;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic [INDEX_W-1:0] index;
    logic               result_valid;
    logic               result_kind;
    logic [BOUND_W-1:0] bottleneck;
    logic               split_after;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [PART_W-1:0]  cfg_data;

    partition_scoreboard sb;
    bit                  steady;
    int                  items_sent;
    int                  cfg_writes;
    int                  cycles;

    linear_partition_min_max_sum_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .value        (value),
        .last         (last),
        .index        (index),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .bottleneck   (bottleneck),
        .split_after  (split_after),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (result_valid === 1'b1)
                sb.check_result(result_kind, bottleneck, split_after);
            if (start === 1'b1 && busy === 1'b0)
                sb.note_item(func, value, last, index);
        end
    end

    task automatic send_item(input logic op, input logic [VALUE_W-1:0] elem,
                             input logic close, input logic [INDEX_W-1:0] pos);
        while (!steady && $urandom_range(0, 99) < 22) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        func  <= op;
        value <= elem;
        last  <= close;
        index <= pos;
        do @(posedge clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    task automatic write_part_count(input logic [PART_W-1:0] pc);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= pc;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_part_count(pc);
        cfg_writes++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(int mode);
        case (mode)
            0: return $urandom_range(0, 15);
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic logic [PART_W-1:0] pick_part_count(int len);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 10'd1;
            2: return '1;
            3: return 10'd512;
            4: return PART_W'($urandom_range(0, 1023));
            default: return PART_W'($urandom_range(1, len + 1));
        endcase
    endfunction

    task automatic send_query(input int len);
        int top;
        top = (len > MAX_ITEMS - 1) ? MAX_ITEMS - 1 : len;
        if ($urandom_range(0, 3) == 0)
            send_item(FUNC_QUERY, $urandom, 1'($urandom_range(0, 1)),
                      INDEX_W'($urandom_range(0, 511)));
        else
            send_item(FUNC_QUERY, $urandom, 1'($urandom_range(0, 1)),
                      INDEX_W'($urandom_range(0, top)));
    endtask

    task automatic run_sequence(input int len, input int mode);
        int nq;
        nq = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_query(len);
            send_item(FUNC_LOAD, pick_value(mode), k == len - 1, INDEX_W'($urandom));
        end
        for (int q = 0; q < nq; q++)
            send_query(len);
    endtask

    initial begin
        int len;
        int mode;
        bit overflow_done;
        sb            = new();
        overflow_done = 1'b0;
        steady        = 1'b0;
        items_sent    = 0;
        cfg_writes    = 0;
        cycles        = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        func      <= FUNC_LOAD;
        value     <= '0;
        last      <= 1'b0;
        index     <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flags read zero after reset; part_count at its reset value
        send_item(FUNC_QUERY, '0, 1'b0, 9'd0);
        send_item(FUNC_QUERY, '1, 1'b1, 9'd511);
        send_item(FUNC_LOAD, 32'd3, 1'b0, '0);
        send_item(FUNC_LOAD, 32'd9, 1'b1, '0);
        send_item(FUNC_QUERY, '0, 1'b0, 9'd0);

        write_part_count(10'd2);
        send_item(FUNC_LOAD, 32'hFFFF_FFFF, 1'b0, '0);
        send_item(FUNC_LOAD, 32'h0, 1'b0, '1);
        send_item(FUNC_LOAD, 32'h8000_0000, 1'b0, '0);
        send_item(FUNC_LOAD, 32'd1, 1'b1, '0);
        send_item(FUNC_QUERY, '0, 1'b0, 9'd0);
        send_item(FUNC_QUERY, '0, 1'b0, 9'd2);

        // zero parts: bound climbs to the total
        write_part_count('0);
        send_item(FUNC_LOAD, 32'd5, 1'b0, '0);
        send_item(FUNC_LOAD, 32'd7, 1'b0, '0);
        send_item(FUNC_LOAD, 32'd3, 1'b1, '0);
        send_item(FUNC_QUERY, '0, 1'b0, 9'd0);

        // more parts than elements: a split after every element but the last
        write_part_count('1);
        send_item(FUNC_LOAD, 32'd4, 1'b0, '0);
        send_item(FUNC_LOAD, 32'd4, 1'b0, '0);
        send_item(FUNC_LOAD, 32'd4, 1'b1, '0);
        send_item(FUNC_QUERY, '0, 1'b0, 9'd0);
        send_item(FUNC_QUERY, '0, 1'b0, 9'd1);
        send_item(FUNC_QUERY, '0, 1'b0, 9'd2);

        write_part_count(10'd512);
        send_item(FUNC_LOAD, 32'hFFFF_FFFF, 1'b1, '0);
        send_item(FUNC_QUERY, '0, 1'b0, 9'd0);

        while (items_sent < ITEM_TARGET) begin
            steady = (items_sent >= 680 && items_sent < 790);
            if (!overflow_done && items_sent >= 60) begin
                // overrun the store: the last two loads drop
                len           = MAX_ITEMS + 2;
                mode          = 1;
                overflow_done = 1'b1;
            end
            else begin
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                mode = $urandom_range(0, 3);
            end
            write_part_count(pick_part_count(len));
            run_sequence(len, mode);
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Ran %0d loads, %0d flag queries and %0d searches over %0d part_count writes",
                 sb.loads, sb.queries, sb.searches, cfg_writes);
        $display("Part counts covered 0, 1, 512 and 1023; one sequence overran the store");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
